/* rtl/mvbp_pkg.sv */
`default_nettype none

package mvbp_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CLASS_W    = 2;
    localparam int unsigned GROUP_SIZE = 16;
    localparam int unsigned POS_W      = $clog2(GROUP_SIZE);
    localparam int unsigned COUNT_W    = 25;
    localparam int unsigned MAX_WORDS  = 16777216;
    localparam int unsigned FIELD_MAX  = (1 << COUNT_W) - 1;
    localparam int unsigned COUNT_CAP  = (MAX_WORDS < FIELD_MAX) ? MAX_WORDS : FIELD_MAX;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [WORD_W-1:0] MISS_FIRST_RST  = 32'd4294959041;
    localparam logic [WORD_W-1:0] MISS_SECOND_RST = 32'd49407;

    localparam logic [CLASS_W-1:0] CLASS_RAW    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_SECOND = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_FIRST  = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_ZERO   = 2'd3;

    localparam logic KIND_RAW    = 1'b0;
    localparam logic KIND_BITMAP = 1'b1;

    localparam logic CFG_MISS_FIRST  = 1'b0;
    localparam logic CFG_MISS_SECOND = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [WORD_W-1:0]  value;
        logic [COUNT_W-1:0] count;
        logic               eor;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_pack_out;

endpackage

`default_nettype wire

/* rtl/mvbp_pack.sv */
`default_nettype none

module mvbp_pack
    import mvbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_index,
    input  wire logic [WORD_W-1:0] i_cfg_data,
    input  wire logic              i_accept,
    input  wire logic [WORD_W-1:0] i_data_word,
    input  wire logic              i_final_word,
    output t_pack_out              o_pack
);

    logic [WORD_W-1:0]  r_miss_first;
    logic [WORD_W-1:0]  r_miss_second;
    logic [WORD_W-1:0]  r_acc;
    logic [POS_W-1:0]   r_pos;
    logic [COUNT_W-1:0] r_count;

    logic [WORD_W-1:0]  n_acc;
    logic [POS_W-1:0]   n_pos;
    logic [COUNT_W-1:0] n_count;

    logic [CLASS_W-1:0] cls;
    logic               is_raw;
    logic [COUNT_W-1:0] count_upd;
    logic [WORD_W-1:0]  acc_upd;
    logic               group_end;
    t_result            raw_res;
    t_result            bmp_res;

    always_comb begin
        if (i_data_word == '0) begin
            cls = CLASS_ZERO;
        end else if (i_data_word == r_miss_first) begin
            cls = CLASS_FIRST;
        end else if (i_data_word == r_miss_second) begin
            cls = CLASS_SECOND;
        end else begin
            cls = CLASS_RAW;
        end
    end

    assign is_raw    = (cls == CLASS_RAW);
    assign count_upd = (is_raw && (r_count < COUNT_W'(COUNT_CAP))) ?
                       r_count + COUNT_W'(1) : r_count;
    assign acc_upd   = r_acc | (WORD_W'(cls) << {r_pos, 1'b0});
    assign group_end = (r_pos == POS_W'(GROUP_SIZE - 1)) || i_final_word;

    always_comb begin
        raw_res.kind  = KIND_RAW;
        raw_res.value = i_data_word;
        raw_res.count = count_upd;
        raw_res.eor   = 1'b0;

        bmp_res.kind  = KIND_BITMAP;
        bmp_res.value = acc_upd;
        bmp_res.count = count_upd;
        bmp_res.eor   = i_final_word;

        o_pack.first  = is_raw ? raw_res : bmp_res;
        o_pack.second = bmp_res;
        o_pack.num    = 2'(is_raw) + 2'(group_end);
    end

    always_comb begin
        n_acc   = r_acc;
        n_pos   = r_pos;
        n_count = r_count;
        if (i_accept) begin
            if (i_final_word) begin
                n_acc   = '0;
                n_pos   = '0;
                n_count = '0;
            end else if (group_end) begin
                n_acc   = '0;
                n_pos   = '0;
                n_count = count_upd;
            end else begin
                n_acc   = acc_upd;
                n_pos   = r_pos + POS_W'(1);
                n_count = count_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_first  <= MISS_FIRST_RST;
            r_miss_second <= MISS_SECOND_RST;
            r_acc         <= '0;
            r_pos         <= '0;
            r_count       <= '0;
        end else begin
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MISS_FIRST:  r_miss_first  <= i_cfg_data;
                    CFG_MISS_SECOND: r_miss_second <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/mvbp_fifo.sv */
`default_nettype none

module mvbp_fifo
    import mvbp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_pack_out i_pack,
    input  wire logic      i_pop,
    output logic           o_valid,
    output logic           o_full,
    output t_result        o_head
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;

    logic [FIFO_PTR_W-1:0]  n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  n_rd_ptr;
    logic [FIFO_CNT_W-1:0]  n_count;

    logic [1:0]             push_num;
    logic                   pop_now;
    logic [FIFO_PTR_W-1:0]  wr_ptr_next;

    assign push_num    = i_push ? i_pack.num : 2'd0;
    assign pop_now     = i_pop && o_valid;
    assign wr_ptr_next = r_wr_ptr + FIFO_PTR_W'(1);

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count > FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(push_num);
        n_rd_ptr = pop_now ? r_rd_ptr + FIFO_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + FIFO_CNT_W'(push_num) - FIFO_CNT_W'(pop_now);
    end

    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_pack.first;
        end
        if (push_num == 2'd2) begin
            r_mem[wr_ptr_next] <= i_pack.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/missing_value_bitmap_packer.sv */
// Missing-value bitmap packer.
// Input channel: i_valid / o_stall with i_data_word and i_final_word. A word is
// taken at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_result_kind, o_result_value,
// o_raw_count and o_end_of_run; a transaction completes where o_valid is high
// and i_stall is low.
// Each word yields zero, one or two results: a raw word first when the word is
// neither zero nor a missing-value word, then the bitmap when its group of 16
// fills or the word is final. The configuration registers are written through
// i_cfg_wr_en / i_cfg_index / i_cfg_data; the user must write them only while
// the block is idle, which the block does not enforce. Throughput: one word per
// cycle while o_stall is low; the output side moves one result per cycle while
// i_stall is low, so words that yield two results are bounded by the output
// rate. Results wait in a four-entry output queue, and o_stall rises while it
// holds three or more. Reset (synchronous, i_rst_n low) empties the queue,
// clears the group and raw counter, and loads the missing-value registers with
// their defaults. While the receiver stalls, the head result holds and words
// keep entering until the queue is nearly full.
`default_nettype none

module missing_value_bitmap_packer
    import mvbp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_index,
    input  wire logic [WORD_W-1:0]  i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [WORD_W-1:0]  i_data_word,
    input  wire logic               i_final_word,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_result_kind,
    output logic [WORD_W-1:0]       o_result_value,
    output logic [COUNT_W-1:0]      o_raw_count,
    output logic                    o_end_of_run
);

    logic      accept;
    logic      full;
    t_pack_out pack;
    t_result   head;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    mvbp_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_data_word  (i_data_word),
        .i_final_word (i_final_word),
        .o_pack       (pack)
    );

    mvbp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_pack  (pack),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_full  (full),
        .o_head  (head)
    );

    assign o_result_kind  = head.kind;
    assign o_result_value = head.value;
    assign o_raw_count    = head.count;
    assign o_end_of_run   = head.eor;

endmodule

`default_nettype wire
